// File: hdl/nrtm_pkg.sv
`timescale 1ns / 1ps

package nrtm_pkg;

  // Operation codes carried on the operation field
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_MATCH = 2'd2;

  // Cells per group in the first level of the priority pick
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned GRP_W    = 3;

  typedef struct packed {
    logic [31:0] subnet;
    logic [31:0] mask;
    logic [31:0] nat;
  } rule_t;

  typedef struct packed {
    logic take_prev;  // load the rule of the cell in front (add shift)
    logic take_next;  // load the rule of the cell behind (delete close-up)
    logic cmp_en;     // register the compare result
  } cell_ctrl_t;

endpackage

// File: hdl/nrtm_cell.sv
`timescale 1ns / 1ps

module nrtm_cell import nrtm_pkg::*; (
  input  logic        clk_i,
  input  cell_ctrl_t  ctrl_i,
  input  logic        valid_i,
  input  rule_t       prev_i,
  input  rule_t       next_i,
  input  logic [31:0] src_i,
  input  logic [31:0] dst_i,
  output rule_t       rule_o,
  output logic        hit_o
);

  rule_t rule_q, rule_d;
  logic  hit_q, hit_d;

  always_comb begin
    priority if (ctrl_i.take_prev) begin
      rule_d = prev_i;
    end else if (ctrl_i.take_next) begin
      rule_d = next_i;
    end else begin
      rule_d = rule_q;
    end
  end

  // Source inside the subnet, destination outside it, and not already translated
  assign hit_d = valid_i
              && ((src_i & rule_q.mask) == (rule_q.subnet & rule_q.mask))
              && ((dst_i & rule_q.mask) != (rule_q.subnet & rule_q.mask))
              && (dst_i != rule_q.nat);

  always_ff @(posedge clk_i) begin
    rule_q <= rule_d;
    if (ctrl_i.cmp_en) begin
      hit_q <= hit_d;
    end
  end

  assign rule_o = rule_q;
  assign hit_o  = hit_q;

endmodule

// File: hdl/nrtm_pick.sv
`timescale 1ns / 1ps

module nrtm_pick import nrtm_pkg::*; #(
  parameter int unsigned NUM = 16,
  parameter int unsigned IW  = 4
) (
  input  logic          clk_i,
  input  logic          grp_en_i,
  input  logic [NUM-1:0] hit_i,
  input  logic [31:0]   nat_i [NUM],
  output logic          hit_o,
  output logic [IW-1:0] idx_o,
  output logic [31:0]   nat_o
);

  localparam int unsigned NG = (NUM + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned NP = NG * GRP_SIZE;

  logic [NP-1:0]    hit_pad;
  logic [31:0]      nat_pad [NP];

  logic             grp_hit_d [NG];
  logic [GRP_W-1:0] grp_idx_d [NG];
  logic [31:0]      grp_nat_d [NG];
  logic             grp_hit_q [NG];
  logic [GRP_W-1:0] grp_idx_q [NG];
  logic [31:0]      grp_nat_q [NG];

  assign hit_pad = NP'(hit_i);

  for (genvar k = 0; k < NP; k++) begin : g_pad
    if (k < NUM) begin : g_real
      assign nat_pad[k] = nat_i[k];
    end else begin : g_fill
      assign nat_pad[k] = '0;
    end
  end

  // First level: lowest hit inside each group of cells
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      grp_nat_d[g] = '0;
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (hit_pad[g * GRP_SIZE + j]) begin
          grp_hit_d[g] = 1'b1;
          grp_idx_d[g] = GRP_W'(j);
          grp_nat_d[g] = nat_pad[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_en_i) begin
      for (int g = 0; g < NG; g++) begin
        grp_hit_q[g] <= grp_hit_d[g];
        grp_idx_q[g] <= grp_idx_d[g];
        grp_nat_q[g] <= grp_nat_d[g];
      end
    end
  end

  // Second level: lowest group that holds a hit
  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    nat_o = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_hit_q[g]) begin
        hit_o = 1'b1;
        idx_o = IW'(g * GRP_SIZE) | IW'(grp_idx_q[g]);
        nat_o = grp_nat_q[g];
      end
    end
  end

endmodule

// File: hdl/nat_rule_table_match.sv
`timescale 1ns / 1ps
// Add, delete and unused codes: the accepted beat goes straight to the result state.
// Match steps: accept, parallel compare in every cell, per-group pick, final pick,
// result. One beat is in flight at a time: no new beat is accepted until the
// result state hands its beat to the output register, which waits on out_stall_i.
// Reset clears the rule count and the handshake state; rule storage is not cleared.

module nat_rule_table_match import nrtm_pkg::*; #(
  parameter int unsigned MAX_RULES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] src_mask_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        done_ok_o,
  output logic [3:0]  hit_index_o,
  output logic [31:0] nat_addr_o,
  output logic [4:0]  rule_count_o
);

  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
  localparam int unsigned NG    = (MAX_RULES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned IW    = $clog2(NG * GRP_SIZE);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_GRP  = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Match key, held for the compare cycle
  logic [31:0] src_q, dst_q;

  // Pending result waiting for the output register
  logic          pend_ok_q, pend_ok_d;
  logic [IW-1:0] pend_idx_q, pend_idx_d;
  logic [31:0]   pend_nat_q, pend_nat_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic        out_ok_q;
  logic [3:0]  out_idx_q;
  logic [31:0] out_nat_q;
  logic [4:0]  out_cnt_q;

  logic in_acc, out_free, res_load;
  logic add_ok, del_ok;

  cell_ctrl_t      ctrl [MAX_RULES];
  rule_t           rule [MAX_RULES];
  logic [MAX_RULES-1:0] hit_vec;
  logic [31:0]     nat_vec [MAX_RULES];
  rule_t           ins_rule;

  logic          pick_hit;
  logic [IW-1:0] pick_idx;
  logic [31:0]   pick_nat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign res_load   = (state_q == ST_RES) && out_free;

  // Add needs a free cell; delete needs a held position
  assign add_ok = in_acc && (operation_i == OP_ADD) && (count_q < CNT_W'(MAX_RULES));
  assign del_ok = in_acc && (operation_i == OP_DEL) && (entry_index_i < 8'(count_q));

  assign ins_rule.subnet = src_addr_i;
  assign ins_rule.mask   = src_mask_i;
  assign ins_rule.nat    = dst_addr_i;

  // Chain of rule cells: position 0 is the newest rule. An add shifts every cell
  // back by one; a delete pulls every cell at or behind the position forward.
  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    rule_t prev_rule, next_rule;

    if (i == 0) begin : g_head
      assign prev_rule = ins_rule;
    end else begin : g_mid
      assign prev_rule = rule[i-1];
    end

    if (i == MAX_RULES - 1) begin : g_tail
      assign next_rule = rule[i];
    end else begin : g_body
      assign next_rule = rule[i+1];
    end

    assign ctrl[i].take_prev = add_ok;
    assign ctrl[i].take_next = del_ok && (8'(i) >= entry_index_i);
    assign ctrl[i].cmp_en    = (state_q == ST_CMP);

    nrtm_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .valid_i (count_q > CNT_W'(i)),
      .prev_i  (prev_rule),
      .next_i  (next_rule),
      .src_i   (src_q),
      .dst_i   (dst_q),
      .rule_o  (rule[i]),
      .hit_o   (hit_vec[i])
    );

    assign nat_vec[i] = rule[i].nat;
  end

  // Two-level registered priority pick of the frontmost hit
  nrtm_pick #(
    .NUM (MAX_RULES),
    .IW  (IW)
  ) u_pick (
    .clk_i    (clk_i),
    .grp_en_i (state_q == ST_GRP),
    .hit_i    (hit_vec),
    .nat_i    (nat_vec),
    .hit_o    (pick_hit),
    .idx_o    (pick_idx),
    .nat_o    (pick_nat)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pend_ok_d  = pend_ok_q;
    pend_idx_d = pend_idx_q;
    pend_nat_d = pend_nat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // Edits finish at accept; hit index and address read zero
          pend_ok_d  = add_ok || del_ok;
          pend_idx_d = '0;
          pend_nat_d = '0;
          if (add_ok) begin
            count_d = count_q + CNT_W'(1);
          end else if (del_ok) begin
            count_d = count_q - CNT_W'(1);
          end
          if (operation_i == OP_MATCH) begin
            state_d = ST_CMP;
          end else begin
            state_d = ST_RES;
          end
        end
      end
      ST_CMP: begin
        state_d = ST_GRP;
      end
      ST_GRP: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        pend_ok_d  = pick_hit;
        pend_idx_d = pick_idx;
        pend_nat_d = pick_nat;
        state_d    = ST_RES;
      end
      ST_RES: begin
        // Hold until the output register can take the beat
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      src_q <= src_addr_i;
      dst_q <= dst_addr_i;
    end
    pend_ok_q  <= pend_ok_d;
    pend_idx_q <= pend_idx_d;
    pend_nat_q <= pend_nat_d;
    if (res_load) begin
      out_ok_q  <= pend_ok_q;
      out_idx_q <= 4'(pend_idx_q);
      out_nat_q <= pend_nat_q;
      out_cnt_q <= 5'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign done_ok_o    = out_ok_q;
  assign hit_index_o  = out_idx_q;
  assign nat_addr_o   = out_nat_q;
  assign rule_count_o = out_cnt_q;

endmodule
